>>> sv/lzwd_pkg.sv
package lzwd_pkg;

  localparam int CODE_W         = 12;
  localparam int LITERAL_COUNT  = 256;
  localparam int MAX_STRING_LEN = 64;
  localparam int BUF_DEPTH      = 64;
  localparam int BUF_AW         = $clog2(BUF_DEPTH);
  localparam int LEN_W          = 7;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              start_of_stream;
  } code_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       status;
    logic       dictionary_frozen;
  } result_t;

  typedef struct packed {
    logic [CODE_W-1:0] prefix;
    logic [7:0]        final_byte;
    logic [7:0]        first_byte;
    logic [LEN_W-1:0]  length;
  } dict_entry_t;

  typedef struct packed {
    logic              en;
    logic [BUF_AW-1:0] addr;
    logic [7:0]        data;
  } buf_wr_t;

  typedef struct packed {
    logic             start;
    logic             err;
    logic             frozen;
    logic [LEN_W-1:0] len;
  } emit_job_t;

  typedef enum logic [1:0] {
    WK_IDLE,
    WK_DECIDE,
    WK_WALK,
    WK_TAIL
  } walk_state_t;

  typedef enum logic {
    EM_IDLE,
    EM_STREAM
  } emit_state_t;

endpackage

>>> sv/lzwd_walker.sv
module lzwd_walker import lzwd_pkg::*; #(
  parameter int DICT_DEPTH = 4096
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       sym_valid,
  output logic       sym_ready,
  input  code_item_t sym,
  input  logic       emit_idle,
  output buf_wr_t    buf_wr,
  output emit_job_t  job
);

  localparam int AW = $clog2(DICT_DEPTH);
  localparam int NW = AW + 1;
  localparam int CW = (NW > CODE_W) ? NW : CODE_W + 1;

  walk_state_t       state, state_next;
  logic [CODE_W-1:0] code_q, code_q_next;
  logic              kwk, kwk_next;
  logic [NW-1:0]     nfc, nfc_next;
  logic [CODE_W-1:0] prev, prev_next;
  logic              have_prev, have_prev_next;
  logic              frozen, frozen_next;
  logic [LEN_W-1:0]  prev_len, prev_len_next;
  logic [7:0]        prev_first, prev_first_next;
  logic [BUF_AW-1:0] pos, pos_next;
  logic [LEN_W-1:0]  tot, tot_next;

  dict_entry_t       mem [DICT_DEPTH];
  dict_entry_t       rdata;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  dict_entry_t       wr_data;

  logic              lit_target;
  logic              invalid;
  logic [LEN_W-1:0]  wl;
  logic [LEN_W-1:0]  wl_m1;
  logic [LEN_W-1:0]  tot_now;
  logic [LEN_W-1:0]  tot_m1;
  logic [LEN_W-1:0]  nl;
  logic [7:0]        first;

  // decision terms, meaningful while the target entry sits in rdata
  assign lit_target = kwk ? (prev < CODE_W'(LITERAL_COUNT))
                          : (code_q < CODE_W'(LITERAL_COUNT));
  assign invalid = (CW'(code_q) >= CW'(DICT_DEPTH))
                 || (!have_prev && (code_q >= CODE_W'(LITERAL_COUNT)))
                 || (have_prev && (CW'(code_q) > CW'(nfc)))
                 || (kwk && (frozen || (prev_len >= LEN_W'(MAX_STRING_LEN))));
  assign wl      = lit_target ? LEN_W'(1) : (kwk ? prev_len : rdata.length);
  assign wl_m1   = wl - LEN_W'(1);
  assign tot_now = wl + LEN_W'(kwk);
  assign tot_m1  = tot - LEN_W'(1);
  assign nl      = prev_len + LEN_W'(1);
  assign first   = kwk ? prev_first : (lit_target ? code_q[7:0] : rdata.first_byte);

  always_comb begin
    state_next      = state;
    code_q_next     = code_q;
    kwk_next        = kwk;
    nfc_next        = nfc;
    prev_next       = prev;
    have_prev_next  = have_prev;
    frozen_next     = frozen;
    prev_len_next   = prev_len;
    prev_first_next = prev_first;
    pos_next        = pos;
    tot_next        = tot;
    sym_ready       = 1'b0;
    rd_en           = 1'b0;
    rd_addr         = AW'(sym.code);
    wr_en           = 1'b0;
    wr_data         = '{prefix: prev, final_byte: first, first_byte: prev_first, length: nl};
    buf_wr          = '0;
    job             = '0;
    case (state)
      WK_IDLE: begin
        sym_ready = emit_idle;
        if (sym_valid && emit_idle) begin
          if (sym.start_of_stream) begin
            nfc_next       = NW'(LITERAL_COUNT);
            prev_next      = '0;
            have_prev_next = 1'b0;
            frozen_next    = 1'b0;
          end
          code_q_next = sym.code;
          kwk_next    = have_prev_next && (CW'(sym.code) == CW'(nfc_next));
          rd_en       = 1'b1;
          rd_addr     = kwk_next ? AW'(prev_next) : AW'(sym.code);
          state_next  = WK_DECIDE;
        end
      end
      WK_DECIDE: begin
        if (invalid) begin
          job.start  = 1'b1;
          job.err    = 1'b1;
          job.len    = LEN_W'(1);
          state_next = WK_IDLE;
        end else begin
          buf_wr = '{en: 1'b1, addr: '0, data: first};
          if (have_prev && !frozen) begin
            if ((nfc == NW'(DICT_DEPTH)) || (nl > LEN_W'(MAX_STRING_LEN))) begin
              frozen_next = 1'b1;
            end else begin
              wr_en    = 1'b1;
              nfc_next = nfc + NW'(1);
              if (nfc_next == NW'(DICT_DEPTH)) begin
                frozen_next = 1'b1;
              end
            end
          end
          prev_next       = code_q;
          have_prev_next  = 1'b1;
          prev_len_next   = tot_now;
          prev_first_next = first;
          tot_next        = tot_now;
          pos_next        = wl_m1[BUF_AW-1:0];
          if (wl == LEN_W'(1)) begin
            if (kwk) begin
              state_next = WK_TAIL;
            end else begin
              job.start  = 1'b1;
              job.len    = tot_now;
              state_next = WK_IDLE;
            end
          end else begin
            state_next = WK_WALK;
          end
        end
      end
      WK_WALK: begin
        buf_wr   = '{en: 1'b1, addr: pos, data: rdata.final_byte};
        rd_en    = 1'b1;
        rd_addr  = AW'(rdata.prefix);
        pos_next = pos - BUF_AW'(1);
        if (pos == BUF_AW'(1)) begin
          if (kwk) begin
            state_next = WK_TAIL;
          end else begin
            job.start  = 1'b1;
            job.len    = tot;
            state_next = WK_IDLE;
          end
        end
      end
      WK_TAIL: begin
        // KwKwK: append the first byte of the previous string
        buf_wr     = '{en: 1'b1, addr: tot_m1[BUF_AW-1:0], data: prev_first};
        job.start  = 1'b1;
        job.len    = tot;
        state_next = WK_IDLE;
      end
      default: begin
        state_next = WK_IDLE;
      end
    endcase
    job.frozen = frozen_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= WK_IDLE;
      nfc       <= NW'(LITERAL_COUNT);
      prev      <= '0;
      have_prev <= 1'b0;
      frozen    <= 1'b0;
    end else begin
      state     <= state_next;
      nfc       <= nfc_next;
      prev      <= prev_next;
      have_prev <= have_prev_next;
      frozen    <= frozen_next;
    end
  end

  always_ff @(posedge clk) begin
    code_q     <= code_q_next;
    kwk        <= kwk_next;
    prev_len   <= prev_len_next;
    prev_first <= prev_first_next;
    pos        <= pos_next;
    tot        <= tot_next;
  end

  // dictionary memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[nfc[AW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  a_start_when_idle: assert property (@(posedge clk) disable iff (rst)
    job.start |-> emit_idle)
    else $error("emit job issued while emitter busy");

  a_full_is_frozen: assert property (@(posedge clk) disable iff (rst)
    (nfc == NW'(DICT_DEPTH)) |-> frozen)
    else $error("dictionary full but not frozen");

  a_walk_pos: assert property (@(posedge clk) disable iff (rst)
    (state == WK_WALK) |-> (pos != '0))
    else $error("chain walk with no position left");

  a_no_write_in_walk: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == WK_DECIDE && (nfc < NW'(DICT_DEPTH))))
    else $error("dictionary write outside decision or beyond depth");

endmodule

>>> sv/lzwd_emitter.sv
module lzwd_emitter import lzwd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  buf_wr_t   buf_wr,
  input  emit_job_t job,
  output logic      emit_idle,
  output logic      dat_valid,
  input  logic      dat_ready,
  output result_t   dat
);

  emit_state_t       state, state_next;
  logic [BUF_AW-1:0] idx, idx_next;
  logic              fetched, fetched_next;
  logic [LEN_W-1:0]  len, len_next;
  logic              err, err_next;
  logic              frozen, frozen_next;

  logic [7:0]        mem [BUF_DEPTH];
  logic [7:0]        rd_data;
  logic              rd_en;
  logic [BUF_AW-1:0] rd_addr;

  logic              take;
  logic              last;
  logic              push;

  assign take      = !dat_valid || dat_ready;
  assign last      = (LEN_W'(idx) + LEN_W'(1)) == len;
  assign push      = (state == EM_STREAM) && fetched && take;
  assign emit_idle = (state == EM_IDLE);

  always_comb begin
    state_next   = state;
    idx_next     = idx;
    fetched_next = fetched;
    len_next     = len;
    err_next     = err;
    frozen_next  = frozen;
    rd_en        = 1'b0;
    rd_addr      = idx;
    case (state)
      EM_IDLE: begin
        if (job.start) begin
          state_next   = EM_STREAM;
          idx_next     = '0;
          fetched_next = 1'b0;
          len_next     = job.len;
          err_next     = job.err;
          frozen_next  = job.frozen;
        end
      end
      EM_STREAM: begin
        rd_en   = !fetched || (push && !last);
        rd_addr = fetched ? idx + BUF_AW'(1) : idx;
        if (rd_en) begin
          fetched_next = 1'b1;
        end
        if (push) begin
          if (last) begin
            state_next   = EM_IDLE;
            fetched_next = 1'b0;
          end else begin
            idx_next = idx + BUF_AW'(1);
          end
        end
      end
      default: begin
        state_next = EM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= EM_IDLE;
      idx       <= '0;
      fetched   <= 1'b0;
      dat_valid <= 1'b0;
    end else begin
      state   <= state_next;
      idx     <= idx_next;
      fetched <= fetched_next;
      if (take) begin
        dat_valid <= push;
      end
    end
  end

  always_ff @(posedge clk) begin
    len    <= len_next;
    err    <= err_next;
    frozen <= frozen_next;
    if (push) begin
      dat <= '{data_byte: err ? 8'd0 : rd_data, last_byte: last, status: err,
               dictionary_frozen: frozen};
    end
  end

  // reverse buffer
  always_ff @(posedge clk) begin
    if (buf_wr.en) begin
      mem[buf_wr.addr] <= buf_wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == EM_STREAM) |-> (LEN_W'(idx) < len))
    else $error("emit index beyond string length");

  a_no_fill_while_streaming: assert property (@(posedge clk) disable iff (rst)
    buf_wr.en |-> (state == EM_IDLE))
    else $error("buffer written while streaming");

  a_err_single: assert property (@(posedge clk) disable iff (rst)
    (state == EM_STREAM && err) |-> (len == LEN_W'(1)))
    else $error("error transaction longer than one result");

endmodule

>>> sv/lzw_byte_decoder_top.sv
// LZW decoder for 12-bit code words. Each code transaction yields the bytes of its string in
// order, one result transaction per byte, with last_byte on the final one; an invalid code
// yields a single result with status set and changes nothing else, but for the dictionary
// reset that start_of_stream brings. The dictionary is one synchronous memory of DICT_DEPTH
// entries, read once per cycle; the prefix chain of a string is walked one link per read, and
// the reversed string is then read back from a 64-byte buffer one byte per cycle while the
// output is not stalled. A new code is taken only once the emitter has handed out the last
// result of the previous code. No clearing pass follows reset.
module lzw_byte_decoder_top import lzwd_pkg::*; #(
  parameter int DICT_DEPTH = 4096
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       sym_valid,
  output logic       sym_ready,
  input  code_item_t sym,
  output logic       dat_valid,
  input  logic       dat_ready,
  output result_t    dat
);

  buf_wr_t   buf_wr;
  emit_job_t job;
  logic      emit_idle;

  lzwd_walker #(
    .DICT_DEPTH(DICT_DEPTH)
  ) u_walker (
    .clk       (clk),
    .rst       (rst),
    .sym_valid (sym_valid),
    .sym_ready (sym_ready),
    .sym       (sym),
    .emit_idle (emit_idle),
    .buf_wr    (buf_wr),
    .job       (job)
  );

  lzwd_emitter u_emitter (
    .clk       (clk),
    .rst       (rst),
    .buf_wr    (buf_wr),
    .job       (job),
    .emit_idle (emit_idle),
    .dat_valid (dat_valid),
    .dat_ready (dat_ready),
    .dat       (dat)
  );

endmodule
